[src/dsz_pkg.sv]
// Shared constants, codes and control types for the dune shadow-zone query block.
package dsz_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_ROWS        = 64;
  localparam int DEF_COLS        = 64;
  localparam int DEF_HEIGHT_BITS = 8;

  // Fixed field widths of the channels
  localparam int POS_W       = 6;
  localparam int IN_H_W      = 8;
  localparam int SLOPE_W     = 12;
  localparam int FRAC_W      = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [SLOPE_W-1:0] SLOPE_RESET = 12'd69;

  // Request kinds carried on in_tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic clr;       // zero the cell at the sweep pointer, advance the pointer
    logic wr;        // store the incoming height
    logic load;      // capture a query's cell and point at it
    logic walk;      // read the cell at the pointer, step one row upstream
    logic own_cap;   // hold the queried cell's own height
    logic acc_init;  // threshold for distance one
    logic acc_step;  // threshold for the next distance
    logic sh_cap;    // hold the shadow verdict
    logic emit;      // load the result register
  } dsz_cmd_t;

  typedef struct packed {
    logic clr_last;  // sweep pointer at the last cell
    logic hit;       // upstream cell in the read register casts shadow
  } dsz_sts_t;

endpackage

[src/dsz_ctrl.sv]
// Controller of the dune shadow-zone query block: clearing sweep, query walk, result handoff.
module dsz_ctrl import dsz_pkg::*; #(
  parameter int ROWS = DEF_ROWS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     in_req_type,
  output logic     out_tvalid,
  input  logic     out_tready,
  output dsz_cmd_t cmd,
  input  dsz_sts_t sts
);

  localparam int KW = $clog2(ROWS);
  localparam logic [KW-1:0] K_LAST = KW'(ROWS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OWN,
    S_FIRST,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [KW-1:0] kcnt_r, kcnt_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic          in_fire;
  logic          slot_free;
  logic          scan_done;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign scan_done = sts.hit || (kcnt_r == K_LAST);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt = state_r;
    kcnt_nxt  = kcnt_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_req_type == REQ_QUERY) begin
            cmd.load  = 1'b1;
            state_nxt = S_OWN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_OWN: begin
        cmd.walk  = 1'b1;
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        cmd.walk     = 1'b1;
        cmd.own_cap  = 1'b1;
        cmd.acc_init = 1'b1;
        kcnt_nxt     = KW'(1);
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.walk = 1'b1;
        if (scan_done) begin
          cmd.sh_cap = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          cmd.acc_step = 1'b1;
          kcnt_nxt     = kcnt_r + KW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      kcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kcnt_r       <= kcnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  a_query_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req_type == REQ_QUERY) |=> (state_r == S_OWN))
    else $error("query accepted but walk did not start");

  a_scan_distance_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (kcnt_r != '0))
    else $error("scan running at distance zero");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten while held");

  a_emit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid_r)
    else $error("loaded result not presented");

endmodule

[src/dsz_datapath.sv]
// Datapath of the dune shadow-zone query block: height memory, upstream pointer, slope compare.
module dsz_datapath import dsz_pkg::*; #(
  parameter int ROWS        = DEF_ROWS,
  parameter int COLS        = DEF_COLS,
  parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dsz_cmd_t           cmd,
  output dsz_sts_t           sts,
  input  logic [POS_W-1:0]   in_row,
  input  logic [POS_W-1:0]   in_col,
  input  logic [IN_H_W-1:0]  in_height,
  input  logic               cfg_valid,
  input  logic [SLOPE_W-1:0] cfg_data,
  output logic [POS_W-1:0]   out_row,
  output logic [POS_W-1:0]   out_col,
  output logic               out_shadow
);

  localparam int CELLS  = ROWS * COLS;
  localparam int AW     = $clog2(CELLS);
  localparam int KW     = $clog2(ROWS);
  localparam int ACC_W  = KW + SLOPE_W;
  localparam int LHS_W  = HEIGHT_BITS + FRAC_W;
  localparam int CMP_W  = (ACC_W > LHS_W) ? ACC_W : LHS_W;
  localparam int POS_N  = 2 ** POS_W;
  localparam logic [AW-1:0] COLS_A = AW'(COLS);
  localparam logic [AW-1:0] WRAP_A = AW'(CELLS - COLS);
  localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);

  // Address reduction tables: index modulo ROWS and modulo COLS
  logic [POS_W-1:0] row_tbl [POS_N];
  logic [POS_W-1:0] col_tbl [POS_N];

  for (genvar i = 0; i < POS_N; i++) begin : g_mod
    localparam int ROW_MOD = i % ROWS;
    localparam int COL_MOD = i % COLS;
    assign row_tbl[i] = POS_W'(ROW_MOD);
    assign col_tbl[i] = POS_W'(COL_MOD);
  end

  logic [HEIGHT_BITS-1:0] mem [CELLS];
  logic [HEIGHT_BITS-1:0] rdata_r;
  logic [HEIGHT_BITS-1:0] own_r;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic [ACC_W-1:0]       acc_r;
  logic [SLOPE_W-1:0]     slope_r;
  logic [POS_W-1:0]       q_row_r, q_col_r;
  logic                   sh_r;
  logic [POS_W-1:0]       out_row_r, out_col_r;
  logic                   out_sh_r;

  logic [POS_W-1:0]       row_red, col_red;
  logic [AW-1:0]          addr_in;
  logic                   mem_we;
  logic [AW-1:0]          waddr;
  logic [HEIGHT_BITS-1:0] wdata;
  logic [HEIGHT_BITS-1:0] diff;
  logic [LHS_W-1:0]       lhs;

  assign row_red = row_tbl[in_row];
  assign col_red = col_tbl[in_col];
  assign addr_in = AW'(row_red) * COLS_A + AW'(col_red);

  assign mem_we = cmd.clr || cmd.wr;
  assign waddr  = cmd.clr ? ptr_r : addr_in;
  assign wdata  = cmd.clr ? '0 : HEIGHT_BITS'(in_height);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.walk) begin
      rdata_r <= mem[ptr_r];
    end
  end

  // Sweep forward while clearing; walk one row upstream per read, wrapping
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.clr) begin
      ptr_nxt = ptr_r + AW'(1);
    end else if (cmd.load) begin
      ptr_nxt = addr_in;
    end else if (cmd.walk) begin
      ptr_nxt = (ptr_r < COLS_A) ? ptr_r + WRAP_A : ptr_r - COLS_A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      slope_r <= SLOPE_RESET;
    end else begin
      ptr_r <= ptr_nxt;
      if (cfg_valid) begin
        slope_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_row_r <= row_red;
      q_col_r <= col_red;
    end
    if (cmd.own_cap) begin
      own_r <= rdata_r;
    end
    if (cmd.acc_init) begin
      acc_r <= ACC_W'(slope_r);
    end else if (cmd.acc_step) begin
      acc_r <= acc_r + ACC_W'(slope_r);
    end
    if (cmd.sh_cap) begin
      sh_r <= sts.hit;
    end
    if (cmd.emit) begin
      out_row_r <= q_row_r;
      out_col_r <= q_col_r;
      out_sh_r  <= sh_r;
    end
  end

  // Shadow when (upstream - own) * 256 exceeds distance * slope
  assign diff = rdata_r - own_r;
  assign lhs  = {diff, {FRAC_W{1'b0}}};

  assign sts.hit      = (rdata_r > own_r) && (CMP_W'(lhs) > CMP_W'(acc_r));
  assign sts.clr_last = (ptr_r == LAST_A);

  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_shadow = out_sh_r;

endmodule

[src/dune_shadow_zone_query.sv]
// Top level of the dune shadow-zone query block.
//
// Input items arrive on in_*: in_tuser selects a height write or a shadow query,
// in_tdata carries row, col and height. A write stores one cell and yields no
// result. A query yields one item on out_*: the reduced row and column and a
// shadow bit. Rows and columns are reduced modulo ROWS and COLS. A query walks
// upstream one row per cycle through the single-port height memory, stopping at
// the first shadowing cell or at distance ROWS-1, so the walk ends at a distance
// k from 1 to ROWS-1. It passes through the states OWN, FIRST, SCAN and EMIT; the
// result register is loaded in EMIT and the block then returns to idle. No new
// item is taken while a query is in progress.
// The result sits in an output register; a stalled receiver holds it there while
// later writes are still taken, and only a finishing query waits for the slot.
// After reset a clearing pass zeroes all ROWS*COLS cells, one per cycle, while
// in_tready stays low. cfg_* writes the shadow slope (Q4.8) and is always ready;
// write it only while the block is idle.
module dune_shadow_zone_query import dsz_pkg::*; #(
  parameter int ROWS        = DEF_ROWS,
  parameter int COLS        = DEF_COLS,
  parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // row[5:0], col[11:6], height[19:12], zero pad
  input  logic                   in_tuser,   // req_type[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_row[5:0], out_col[11:6], in_shadow[12], pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SLOPE_W-1:0]     cfg_data
);

  dsz_cmd_t         cmd;
  dsz_sts_t         sts;
  logic [POS_W-1:0] res_row, res_col;
  logic             res_shadow;

  assign cfg_ready = 1'b1;

  dsz_ctrl #(
    .ROWS (ROWS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_req_type (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .sts         (sts)
  );

  dsz_datapath #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_row     (in_tdata[POS_W-1:0]),
    .in_col     (in_tdata[2*POS_W-1:POS_W]),
    .in_height  (in_tdata[2*POS_W+IN_H_W-1:2*POS_W]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_row    (res_row),
    .out_col    (res_col),
    .out_shadow (res_shadow)
  );

  assign out_tdata = {{(OUT_TDATA_W - 2*POS_W - 1){1'b0}}, res_shadow, res_col, res_row};

endmodule
